[hdl/gsb_pkg.sv]
// Shared types and constants for the frame blending pixel pipeline.
package gsb_pkg;

    // Table geometry: one 8-bit entry per 8-bit component code
    localparam int TBL_WIDTH = 8;
    localparam int TBL_DEPTH = 256;

    // Item type codes
    localparam logic [1:0] MODE_PIXEL  = 2'd0;
    localparam logic [1:0] MODE_DEC_WR = 2'd1;
    localparam logic [1:0] MODE_ENC_WR = 2'd2;

    // Blend mode register codes
    localparam logic [2:0] BM_3C_ADAPT = 3'd0;
    localparam logic [2:0] BM_2C_ADAPT = 3'd1;
    localparam logic [2:0] BM_2C_FULL  = 3'd2;
    localparam logic [2:0] BM_3C_FULL  = 3'd3;
    localparam logic [2:0] BM_PASS     = 3'd4;

    // Configuration register indexes
    localparam logic CFG_BLEND_MODE  = 1'b0;
    localparam logic CFG_BLEND_RATIO = 1'b1;

    // Ratio is unsigned Q1.8, 256 is unity
    localparam logic [8:0] RATIO_ONE   = 9'd256;
    localparam logic [8:0] RATIO_RESET = 9'd128;

    // Which blend a pixel gets
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_TWO   = 2'd1,
        KIND_THREE = 2'd2
    } blend_kind_t;

    // Per-stage control (reset) and payload (no reset)
    typedef struct packed {
        logic pix;
        logic enc_wr;
    } stage_ctrl_t;

    typedef struct packed {
        blend_kind_t kind;
        logic [31:0] pixel;
        logic [7:0]  idx;
        logic [7:0]  val;
    } stage_data_t;

endpackage

[hdl/gsb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gsb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/gsb_chan.sv]
// One color component: three-frame average, then linear-light mix to an encode index.
module gsb_chan import gsb_pkg::*; (
    input  logic        clk,
    input  blend_kind_t kind,
    input  logic [7:0]  d0,
    input  logic [7:0]  d1,
    input  logic [7:0]  d2,
    input  logic [8:0]  ratio,
    output logic [7:0]  lin
);

    // sum / 3 as sum * 683 >> 11, exact for sums up to 767
    localparam logic [9:0] RECIP_3 = 10'd683;

    logic [9:0]  sum;
    logic [18:0] avg_prod;
    logic [7:0]  avg_reg;
    logic [7:0]  d0_reg;
    logic [7:0]  d1_reg;
    logic        three_reg;

    logic signed [8:0]  diff;
    logic signed [10:0] wgt;
    logic signed [19:0] prod;
    logic signed [19:0] base;
    logic signed [19:0] mix;

    // Stage one: average of the three decoded frames
    assign sum      = {2'b00, d0} + {2'b00, d1} + {2'b00, d2};
    assign avg_prod = 19'(sum * RECIP_3);

    always_ff @(posedge clk)
    begin
        avg_reg   <= avg_prod[18:11];
        d0_reg    <= d0;
        d1_reg    <= d1;
        three_reg <= (kind == KIND_THREE);
    end

    // Stage two: d0*256 + (other - d0) * weight; 3C uses twice the ratio
    always_comb
    begin
        if (three_reg)
        begin
            diff = signed'({1'b0, avg_reg}) - signed'({1'b0, d0_reg});
            wgt  = signed'({1'b0, ratio, 1'b0});
        end
        else
        begin
            diff = signed'({1'b0, d1_reg}) - signed'({1'b0, d0_reg});
            wgt  = signed'({2'b00, ratio});
        end
        prod = diff * wgt;
        base = signed'({4'b0000, d0_reg, 8'h00});
        mix  = base + prod;
    end

    // Negative clamps to zero, overflow clamps to 255
    always_comb
    begin
        if (mix[19])
        begin
            lin = 8'h00;
        end
        else if (mix[18:16] != 3'b000)
        begin
            lin = 8'hFF;
        end
        else
        begin
            lin = mix[15:8];
        end
    end

endmodule

[hdl/gigascreen_pixel_blend.sv]
// Top level: anti-flicker RGBA pixel blend with loadable decode and encode tables.
//
// Takes one word per clock: busy never rises, so start may be held high for a
// continuous stream. A pixel word gives exactly one result on pixel_out and
// was_blended, marked by done for one cycle. The word is registered in order
// by the decode table read, the average register, the encode table read
// (addressed by the combinational mix) and the output register. The results
// cannot be held off, so the receiver must take each one in its done cycle.
// Table write words give no result. A decode write takes effect for the next
// word; an encode write travels the pipeline with the pixels so ordering is
// kept. Both tables power up unknown and must be loaded before pixels that
// read them. Write blend_mode and blend_ratio only while no pixel is in flight.
module gigascreen_pixel_blend import gsb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] pixel_now,
    input  logic [31:0] frame_back_one,
    input  logic [31:0] frame_back_two,
    input  logic [31:0] frame_back_three,
    input  logic [31:0] frame_back_four,
    input  logic [31:0] frame_back_five,
    input  logic [7:0]  table_index,
    input  logic [7:0]  table_value,
    // result channel
    output logic        done,
    output logic [31:0] pixel_out,
    output logic        was_blended,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_data
);

    localparam int TBL_AW = $clog2(TBL_DEPTH);

    logic        accept;
    logic [2:0]  blend_mode_reg;
    logic [8:0]  blend_ratio_reg;
    logic [8:0]  ratio_sat;

    logic [31:0] frames [3];
    logic        eq01;
    logic        eq02;
    logic        still;
    logic        two_adapt;
    logic        single_comp;
    logic        history_match;
    blend_kind_t kind_next;

    stage_ctrl_t s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg;
    stage_data_t s1_data_reg, s2_data_reg, s3_data_reg;
    stage_ctrl_t s1_ctrl_next;
    stage_data_t s1_data_next;

    logic [TBL_WIDTH-1:0] dec_q [3][3];
    logic [TBL_WIDTH-1:0] enc_q [3];
    logic [7:0]           lin   [3];

    logic        done_reg;
    logic [31:0] pixel_out_reg;
    logic        was_blended_reg;
    logic [31:0] pixel_out_next;

    // More than one nonzero RGB component
    function automatic logic multi_comp(input logic [31:0] c);
        logic [1:0] n;
        n = 2'(c[7:0] != 8'h00) + 2'(c[15:8] != 8'h00) + 2'(c[23:16] != 8'h00);
        return n > 2'd1;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg  <= BM_PASS;
            blend_ratio_reg <= RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_BLEND_MODE:  blend_mode_reg  <= cfg_data[2:0];
                CFG_BLEND_RATIO: blend_ratio_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign ratio_sat = (blend_ratio_reg > RATIO_ONE) ? RATIO_ONE : blend_ratio_reg;

    // Blend decision from whole words, alpha included
    assign frames[0] = pixel_now;
    assign frames[1] = frame_back_one;
    assign frames[2] = frame_back_two;

    assign eq01          = (pixel_now == frame_back_one);
    assign eq02          = (pixel_now == frame_back_two);
    assign still         = eq01 && eq02;
    assign two_adapt     = eq02 && !eq01;
    assign single_comp   = !(multi_comp(pixel_now) || multi_comp(frame_back_one) ||
                             multi_comp(frame_back_two));
    assign history_match = (pixel_now == frame_back_three) &&
                           (frame_back_one == frame_back_four) &&
                           (frame_back_two == frame_back_five);

    always_comb
    begin
        kind_next = KIND_NONE;
        case (blend_mode_reg)
            BM_3C_ADAPT:
            begin
                if (!still)
                begin
                    if (single_comp && history_match)
                    begin
                        kind_next = KIND_THREE;
                    end
                    else if (two_adapt)
                    begin
                        kind_next = KIND_TWO;
                    end
                end
            end
            BM_2C_ADAPT:
            begin
                if (two_adapt)
                begin
                    kind_next = KIND_TWO;
                end
            end
            BM_2C_FULL:
            begin
                if (!eq01)
                begin
                    kind_next = KIND_TWO;
                end
            end
            BM_3C_FULL:
            begin
                if (!still)
                begin
                    kind_next = KIND_THREE;
                end
            end
            default:
            begin
                kind_next = KIND_NONE;
            end
        endcase
    end

    // Stage one entry
    assign s1_ctrl_next.pix    = accept && (mode == MODE_PIXEL);
    assign s1_ctrl_next.enc_wr = accept && (mode == MODE_ENC_WR);
    assign s1_data_next.kind   = kind_next;
    assign s1_data_next.pixel  = pixel_now;
    assign s1_data_next.idx    = table_index;
    assign s1_data_next.val    = table_value;

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_data_reg <= s1_data_next;
        s2_data_reg <= s1_data_reg;
        s3_data_reg <= s2_data_reg;
    end

    // Decode tables: one copy per frame and component, all written together
    for (genvar f = 0; f < 3; f++)
    begin : g_dec_frame
        for (genvar k = 0; k < 3; k++)
        begin : g_dec_comp
            gsb_ram #(
                .DATA_W (TBL_WIDTH),
                .DEPTH  (TBL_DEPTH)
            ) u_dec_ram (
                .clk   (clk),
                .we    (accept && (mode == MODE_DEC_WR)),
                .waddr (table_index),
                .wdata (table_value),
                .raddr (frames[f][8*k +: TBL_AW]),
                .rdata (dec_q[f][k])
            );
        end
    end

    // Per-component mix and encode table lookup
    for (genvar k = 0; k < 3; k++)
    begin : g_comp
        gsb_chan u_chan (
            .clk   (clk),
            .kind  (s1_data_reg.kind),
            .d0    (dec_q[0][k]),
            .d1    (dec_q[1][k]),
            .d2    (dec_q[2][k]),
            .ratio (ratio_sat),
            .lin   (lin[k])
        );

        gsb_ram #(
            .DATA_W (TBL_WIDTH),
            .DEPTH  (TBL_DEPTH)
        ) u_enc_ram (
            .clk   (clk),
            .we    (s2_ctrl_reg.enc_wr),
            .waddr (s2_data_reg.idx),
            .wdata (s2_data_reg.val),
            .raddr (lin[k]),
            .rdata (enc_q[k])
        );
    end

    // Output word: blended pixels drop alpha
    assign pixel_out_next = (s3_data_reg.kind == KIND_NONE) ? s3_data_reg.pixel :
                            {8'h00, enc_q[2], enc_q[1], enc_q[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_ctrl_reg.pix;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg   <= pixel_out_next;
        was_blended_reg <= (s3_data_reg.kind != KIND_NONE);
    end

    assign done        = done_reg;
    assign pixel_out   = pixel_out_reg;
    assign was_blended = was_blended_reg;

endmodule
